// ----- src/sabm_pkg.sv -----
// Shared types, register codes and arithmetic helpers for the blend pipeline.
// No dependencies; used by sabm_div and straight_alpha_blend_modes.
`default_nettype none

package sabm_pkg;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_SCREEN   = 2'd1,
    MODE_MULTIPLY = 2'd2
  } op_mode_e;

  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_OPACITY = 1'b1
  } cfg_reg_e;

  localparam logic [8:0] OPACITY_FULL = 9'd256;

  // Index 0 red, 1 green, 2 blue, 3 alpha.
  typedef logic [3:0][7:0] pix_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
    logic [7:0] den;
    logic       sat;
  } div_st_t;

  // Exact floor(p / 255) for any p up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic div_st_t div_init(input logic [15:0] num, input logic [7:0] den);
    div_st_t r;
    r.rem = num[15:8];
    r.low = num[7:0];
    r.quo = 8'd0;
    r.den = den;
    r.sat = (num[15:8] >= den);
    return r;
  endfunction

  // Two restoring division steps.
  function automatic div_st_t div_step(input div_st_t st);
    div_st_t    r;
    logic [8:0] part;
    r = st;
    for (int i = 0; i < 2; i++) begin
      part  = {r.rem, r.low[7]};
      r.low = {r.low[6:0], 1'b0};
      if (part >= {1'b0, r.den}) begin
        r.rem = 8'(part - {1'b0, r.den});
        r.quo = {r.quo[6:0], 1'b1};
      end else begin
        r.rem = part[7:0];
        r.quo = {r.quo[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/sabm_div.sv -----
// Four-stage pipelined 16-by-8 bit divider with a quotient saturated to 255.
// Depends on sabm_pkg for the step state and step functions.
`default_nettype none

module sabm_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic      [7:0]  quo_o
);

  sabm_pkg::div_st_t st_q [4];
  sabm_pkg::div_st_t st_d [4];

  always_comb begin
    st_d[0] = sabm_pkg::div_step(sabm_pkg::div_init(num_i, den_i));
    for (int k = 1; k < 4; k++) begin
      st_d[k] = sabm_pkg::div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign quo_o = st_q[3].sat ? 8'hFF : st_q[3].quo;

endmodule

`default_nettype wire

// ----- src/straight_alpha_blend_modes.sv -----
// Screen and multiply blending of straight-alpha RGBA8 pixels with opacity mix.
// Depends on sabm_pkg and sabm_div.
// Throughput is one pixel per cycle while the output is not stalled;
// two chained banks of four-stage dividers set the depth.
// Reset empties the pipeline and sets the mode to none and opacity to 256.
`default_nettype none

module straight_alpha_blend_modes (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] src_red_i,
  input  wire logic [7:0] src_green_i,
  input  wire logic [7:0] src_blue_i,
  input  wire logic [7:0] src_alpha_i,
  input  wire logic [7:0] dst_red_i,
  input  wire logic [7:0] dst_green_i,
  input  wire logic [7:0] dst_blue_i,
  input  wire logic [7:0] dst_alpha_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] out_red_o,
  output logic      [7:0] out_green_o,
  output logic      [7:0] out_blue_o,
  output logic      [7:0] out_alpha_o
);

  typedef struct packed {
    sabm_pkg::pix_t  s;
    sabm_pkg::pix_t  d;
    logic [2:0][7:0] ps;
    logic [7:0]      a;
  } sb1_t;

  typedef struct packed {
    sabm_pkg::pix_t s;
    sabm_pkg::pix_t b;
    logic [7:0]     a;
  } sb2_t;

  logic [1:0]  mode_q;
  logic [8:0]  opac_q;
  logic        en;
  logic        blend_on;
  logic        is_mul;
  logic        w_zero;
  logic        w_full;
  logic [7:0]  w8;
  logic [7:0]  iw8;
  logic [14:0] vld_q;
  logic        out_valid_q;
  sabm_pkg::pix_t out_q;
  sabm_pkg::pix_t out_d;
  sabm_pkg::pix_t src_in;
  sabm_pkg::pix_t dst_in;

  sabm_pkg::pix_t   s1_q, d1_q;
  logic [2:0][15:0] psp1_q, psp1_d, pdp1_q, pdp1_d;
  logic [15:0]      sdp1_q, sdp1_d;

  sabm_pkg::pix_t   s2_q, d2_q;
  logic [2:0][7:0]  ps2_q, ps2_d, pd2_q, pd2_d;
  logic [2:0][15:0] prod2_q, prod2_d;
  logic [7:0]       a2_q, a2_d;

  sabm_pkg::pix_t   s3_q, d3_q;
  logic [2:0][7:0]  ps3_q;
  logic [2:0][15:0] num3_q, num3_d;
  logic [7:0]       a3_q;

  sb1_t             sb1_q [4];
  logic [2:0][7:0]  bq;

  sabm_pkg::pix_t   b8_d;
  sabm_pkg::pix_t   s8_q, b8_q;
  logic [2:0][7:0]  ps8_q;
  logic [2:0][15:0] bprod8_q, bprod8_d;
  logic [15:0]      mixa8_q, mixa8_d;

  sabm_pkg::pix_t   s9_q, b9_q;
  logic [2:0][7:0]  ps9_q, pdm9_q, pdm9_d;
  logic [7:0]       alpha9_q, alpha9_d;
  logic [15:0]      mix_rnd;

  sabm_pkg::pix_t   s10_q, b10_q;
  logic [2:0][15:0] m10_q, m10_d;
  logic [7:0]       alpha10_q;

  sabm_pkg::pix_t   s11_q, b11_q;
  logic [2:0][15:0] n11_q, n11_d;
  logic [7:0]       alpha11_q;

  sb2_t             sb2_q [4];
  logic [2:0][7:0]  cq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sabm_pkg::MODE_NONE;
      opac_q <= sabm_pkg::OPACITY_FULL;
    end else if (cfg_valid_i) begin
      unique case (sabm_pkg::cfg_reg_e'(cfg_index_i))
        sabm_pkg::REG_MODE:    mode_q <= cfg_data_i[1:0];
        sabm_pkg::REG_OPACITY: opac_q <= cfg_data_i;
      endcase
    end
  end

  assign blend_on = (mode_q == sabm_pkg::MODE_SCREEN) || (mode_q == sabm_pkg::MODE_MULTIPLY);
  assign is_mul   = (mode_q == sabm_pkg::MODE_MULTIPLY);
  assign w_zero   = (opac_q == 9'd0);
  assign w_full   = (opac_q >= sabm_pkg::OPACITY_FULL);
  assign w8       = opac_q[7:0];
  assign iw8      = 8'(sabm_pkg::OPACITY_FULL - {1'b0, w8});

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[13:0], in_valid_i};
      out_valid_q <= vld_q[14];
    end
  end

  assign src_in = {src_alpha_i, src_blue_i, src_green_i, src_red_i};
  assign dst_in = {dst_alpha_i, dst_blue_i, dst_green_i, dst_red_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      psp1_d[c] = 16'(src_in[c]) * 16'(src_in[3]);
      pdp1_d[c] = 16'(dst_in[c]) * 16'(dst_in[3]);
    end
    sdp1_d = 16'(src_in[3]) * 16'(dst_in[3]);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ps2_d[c]   = sabm_pkg::div255(psp1_q[c]);
      pd2_d[c]   = sabm_pkg::div255(pdp1_q[c]);
      prod2_d[c] = is_mul ? 16'(8'(ps2_d[c] + ~s1_q[3])) * 16'(8'(pd2_d[c] + ~d1_q[3]))
                          : 16'(ps2_d[c]) * 16'(pd2_d[c]);
    end
    a2_d = 8'({1'b0, s1_q[3]} + {1'b0, d1_q[3]} - {1'b0, sabm_pkg::div255(sdp1_q)});
  end

  always_comb begin
    logic [7:0] m;
    logic [8:0] sum;
    logic [7:0] t;
    for (int c = 0; c < 3; c++) begin
      m   = sabm_pkg::div255(prod2_q[c]);
      sum = {1'b0, m} + {1'b0, a2_q};
      if (is_mul) begin
        t = (sum < 9'd255) ? 8'd0 : 8'(sum - 9'd255);
      end else begin
        t = 8'({1'b0, ps2_q[c]} + {1'b0, pd2_q[c]} - {1'b0, m});
      end
      num3_d[c] = {t, 8'd0} - {8'd0, t};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= src_in;
      d1_q    <= dst_in;
      psp1_q  <= psp1_d;
      pdp1_q  <= pdp1_d;
      sdp1_q  <= sdp1_d;
      s2_q    <= s1_q;
      d2_q    <= d1_q;
      ps2_q   <= ps2_d;
      pd2_q   <= pd2_d;
      prod2_q <= prod2_d;
      a2_q    <= a2_d;
      s3_q    <= s2_q;
      d3_q    <= d2_q;
      ps3_q   <= ps2_q;
      num3_q  <= num3_d;
      a3_q    <= a2_q;
      sb1_q[0] <= '{s: s3_q, d: d3_q, ps: ps3_q, a: a3_q};
      for (int k = 1; k < 4; k++) begin
        sb1_q[k] <= sb1_q[k-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_blend_div
    sabm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num3_q[c]),
      .den_i (a3_q),
      .quo_o (bq[c])
    );
  end

  always_comb begin
    if (!blend_on || sb1_q[3].s[3] == 8'd0) begin
      b8_d = sb1_q[3].d;
    end else if (sb1_q[3].d[3] == 8'd0) begin
      b8_d = sb1_q[3].s;
    end else begin
      b8_d = {sb1_q[3].a, bq[2], bq[1], bq[0]};
    end
    for (int c = 0; c < 3; c++) begin
      bprod8_d[c] = 16'(b8_d[c]) * 16'(b8_d[3]);
    end
    mixa8_d = 16'(16'(b8_d[3]) * 16'(w8) + 16'(sb1_q[3].s[3]) * 16'(iw8));
  end

  always_comb begin
    logic [23:0] x;
    for (int c = 0; c < 3; c++) begin
      pdm9_d[c] = sabm_pkg::div255(bprod8_q[c]);
      m10_d[c]  = 16'(16'(pdm9_q[c]) * 16'(w8) + 16'(ps9_q[c]) * 16'(iw8));
      x         = {m10_q[c], 8'd0} - {8'd0, m10_q[c]} + {9'd0, alpha10_q, 7'd0};
      n11_d[c]  = x[23:8];
    end
    mix_rnd  = mixa8_q + 16'd128;
    alpha9_d = mix_rnd[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q      <= sb1_q[3].s;
      b8_q      <= b8_d;
      ps8_q     <= sb1_q[3].ps;
      bprod8_q  <= bprod8_d;
      mixa8_q   <= mixa8_d;
      s9_q      <= s8_q;
      b9_q      <= b8_q;
      ps9_q     <= ps8_q;
      pdm9_q    <= pdm9_d;
      alpha9_q  <= alpha9_d;
      s10_q     <= s9_q;
      b10_q     <= b9_q;
      m10_q     <= m10_d;
      alpha10_q <= alpha9_q;
      s11_q     <= s10_q;
      b11_q     <= b10_q;
      n11_q     <= n11_d;
      alpha11_q <= alpha10_q;
      sb2_q[0]  <= '{s: s11_q, b: b11_q, a: alpha11_q};
      for (int k = 1; k < 4; k++) begin
        sb2_q[k] <= sb2_q[k-1];
      end
      out_q     <= out_d;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_mix_div
    sabm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (n11_q[c]),
      .den_i (alpha11_q),
      .quo_o (cq[c])
    );
  end

  always_comb begin
    if (w_zero) begin
      out_d = sb2_q[3].s;
    end else if (w_full) begin
      out_d = sb2_q[3].b;
    end else if (sb2_q[3].a == 8'd0) begin
      out_d = '0;
    end else begin
      out_d = {sb2_q[3].a, cq[2], cq[1], cq[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

  a_union_alpha : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && blend_on && s3_q[3] != 8'd0 && d3_q[3] != 8'd0)
      |-> (a3_q >= s3_q[3] && a3_q >= d3_q[3]))
    else $error("union alpha below an operand alpha");

  a_mix_alpha : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[8] && !w_zero && !w_full) |-> (alpha9_q <= b9_q[3] || alpha9_q <= s9_q[3]))
    else $error("mixed alpha exceeds both operand alphas");

  a_reset_empty : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

`default_nettype wire
